FILE: src/iur_pkg.sv
// iur_pkg: shared types, codes and the crc-32 byte update for the image upload receiver
// no dependencies; imported by iur_ctrl, iur_out_seq and the top level
`default_nettype none

package iur_pkg;

    localparam int CHUNK_LEN_DEF = 64;
    localparam int MAX_IMAGE_DEF = 262144;

    // results one received byte can cause at most
    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    localparam int LIMIT_W = 19;
    localparam int ADDR_W  = 18;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'h40000;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_MEM    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE = 3'd2;
    localparam logic [2:0] ST_BAD_CMD  = 3'd3;
    localparam logic [2:0] ST_CRC_BAD  = 3'd4;

    // led drive
    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_WAIT  = 2'd1;
    localparam logic [1:0] LED_LOADA = 2'd2;
    localparam logic [1:0] LED_LOADB = 2'd3;

    // protocol characters
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_B  = 8'h42;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_Z  = 8'h5A;
    localparam logic [7:0] CH_LR = 8'h72;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        byte_value;
        logic [ADDR_W-1:0] write_address;
        logic [1:0]        led_pattern;
        logic [2:0]        status;
    } result_t;

    // a group of results handed from the control to the output sequencer
    typedef struct packed {
        logic                     load;
        logic [CNT_W-1:0]         cnt;
        result_t [MAX_RES-1:0]    res;
    } bundle_t;

    function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] value,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [1:0] led, input logic [2:0] st);
        result_t r;
        r.kind          = kind;
        r.byte_value    = value;
        r.write_address = addr;
        r.led_pattern   = led;
        r.status        = st;
        return r;
    endfunction

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/image_upload_receiver_crc32_core.sv
// image_upload_receiver_crc32_core: top level of the serial image upload receiver
// depends on iur_pkg, iur_in_stage, iur_ctrl and iur_out_seq
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------------------------
// rx        | in        | in_valid/in_stall  | rx_byte
// result    | out       | out_valid/out_stall| kind byte_value write_address led_pattern
//           |           |                    | status last
// config    | in        | max_image_bytes_we | max_image_bytes
//
// a received byte is held in the input register, then the control stage handles it
//   combinationally and loads its results into the result register
// a byte can be taken every cycle unless its results must wait; results leave one per cycle
//   unless stalled; a byte's k results hold back the next one (data bytes: 1, chunk ends: 2)
// the result register is freed in the same cycle its last result is taken
// reset clears all protocol state; crc starts at all ones, ack letter at 'C'
// stalls on the result side back up into in_stall once the input register is full

module image_upload_receiver_crc32_core
    import iur_pkg::*;
#(
    parameter int CHUNK_LEN = CHUNK_LEN_DEF,
    parameter int MAX_IMAGE = MAX_IMAGE_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // configuration write
    input  wire logic               max_image_bytes_we,
    input  wire logic [LIMIT_W-1:0] max_image_bytes,

    // received byte requests
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,

    // result requests
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic [7:0]              byte_value,
    output logic [ADDR_W-1:0]       write_address,
    output logic [1:0]              led_pattern,
    output logic [2:0]              status,
    output logic                    last
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_take;
    logic       load_ok;
    bundle_t    bundle;
    result_t    head;

    // input register
    iur_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    // protocol sequencing, size limit, crc and result building
    iur_ctrl #(
        .CHUNK_LEN (CHUNK_LEN),
        .MAX_IMAGE (MAX_IMAGE)
    ) u_ctrl
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .max_image_bytes_we (max_image_bytes_we),
        .max_image_bytes    (max_image_bytes),
        .byte_valid         (byte_valid),
        .byte_data          (byte_data),
        .byte_take          (byte_take),
        .load_ok            (load_ok),
        .bundle             (bundle)
    );

    // result register, drained in order
    iur_out_seq u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bundle    (bundle),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .head_last (last)
    );

    // unpack the head result onto the field ports
    assign kind          = head.kind;
    assign byte_value    = head.byte_value;
    assign write_address = head.write_address;
    assign led_pattern   = head.led_pattern;
    assign status        = head.status;

endmodule

`default_nettype wire

FILE: src/iur_in_stage.sv
// iur_in_stage: one-entry input register for received bytes
// standalone, no package use
`default_nettype none

module iur_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            byte_valid,
    output logic [7:0]      byte_data,
    input  wire logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall   = valid_reg && !byte_take;
    assign accept     = in_valid && !in_stall;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (byte_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

FILE: src/iur_ctrl.sv
// iur_ctrl: protocol state, size check, crc-32 and result building for one byte per cycle
// unless the byte's results must wait; uses iur_pkg; feeds bundles to iur_out_seq
`default_nettype none

module iur_ctrl
    import iur_pkg::*;
#(
    parameter int CHUNK_LEN = CHUNK_LEN_DEF,
    parameter int MAX_IMAGE = MAX_IMAGE_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               max_image_bytes_we,
    input  wire logic [LIMIT_W-1:0] max_image_bytes,
    input  wire logic               byte_valid,
    input  wire logic [7:0]         byte_data,
    output logic                    byte_take,
    input  wire logic               load_ok,
    output bundle_t                 bundle
);

    localparam int FILL_W = $clog2(CHUNK_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CHUNK_LEN);
    localparam logic [31:0] MAX_IMAGE_32 = 32'(MAX_IMAGE);

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_SIZE = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    logic [2:0]         phase_reg,  phase_next;
    logic [1:0]         fbi_reg,    fbi_next;
    logic [31:0]        size_reg,   size_next;
    logic [LIMIT_W-1:0] rcv_reg,    rcv_next;
    logic [FILL_W-1:0]  fill_reg,   fill_next;
    logic               parity_reg, parity_next;
    logic [31:0]        crc_reg,    crc_next;
    logic [31:0]        exp_reg,    exp_next;
    logic [7:0]         ack_reg,    ack_next;
    logic [1:0]         led_reg,    led_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic [31:0]        limit_eff;
    logic [31:0]        word_merged;
    logic [31:0]        word_base;
    logic [31:0]        calc;
    logic [LIMIT_W-1:0] rcv_inc;
    logic [FILL_W-1:0]  fill_inc;
    logic               chunk_full;
    logic               image_done;
    logic               par_flip;
    logic [CNT_W-1:0]   n;
    result_t [MAX_RES-1:0] res;
    logic               proceed;

    assign limit_eff = (32'(limit_reg) < MAX_IMAGE_32) ? 32'(limit_reg) : MAX_IMAGE_32;
    assign calc      = ~crc_reg;
    assign rcv_inc   = rcv_reg + 1'b1;
    assign fill_inc  = fill_reg + 1'b1;
    assign chunk_full = (fill_inc == FILL_FULL);
    assign image_done = (32'(rcv_inc) >= size_reg);
    assign par_flip   = parity_reg ^ chunk_full;

    // little-endian field gathering, shared by size and expected crc
    assign word_base = (phase_reg == PH_SIZE) ? size_reg : exp_reg;
    always_comb
    begin
        word_merged = word_base;
        case (fbi_reg)
            2'd0:    word_merged[7:0]   = byte_data;
            2'd1:    word_merged[15:8]  = byte_data;
            2'd2:    word_merged[23:16] = byte_data;
            default: word_merged[31:24] = byte_data;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        size_next   = size_reg;
        rcv_next    = rcv_reg;
        fill_next   = fill_reg;
        parity_next = parity_reg;
        crc_next    = crc_reg;
        exp_next    = exp_reg;
        ack_next    = ack_reg;
        led_next    = led_reg;
        n           = '0;
        res         = '0;

        case (phase_reg)
            PH_WAIT:
            begin
                if (byte_data == CH_R || byte_data == CH_LR)
                begin
                    led_next   = LED_LOADA;
                    res[0]     = mk_result(KIND_TX, CH_A, '0, LED_LOADA, ST_RUN);
                    n          = CNT_W'(1);
                    phase_next = PH_SIZE;
                    fbi_next   = '0;
                    size_next  = '0;
                end
            end
            PH_SIZE:
            begin
                size_next = word_merged;
                if (fbi_reg != 2'd3)
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
                else
                begin
                    fbi_next = '0;
                    res[0]   = mk_result(KIND_TX, CH_B, '0, led_reg, ST_RUN);
                    n        = CNT_W'(1);
                    if (word_merged == 32'd0 || word_merged > limit_eff)
                    begin
                        led_next   = LED_OFF;
                        res[1]     = mk_result(KIND_STATUS, 8'd0, '0, LED_OFF, ST_BAD_SIZE);
                        n          = CNT_W'(2);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        phase_next  = PH_DATA;
                        rcv_next    = '0;
                        fill_next   = '0;
                        parity_next = 1'b0;
                    end
                end
            end
            PH_DATA:
            begin
                res[0]    = mk_result(KIND_MEM, byte_data, rcv_reg[ADDR_W-1:0], led_reg, ST_RUN);
                n         = CNT_W'(1);
                crc_next  = crc_byte(crc_reg, byte_data);
                rcv_next  = rcv_inc;
                fill_next = fill_inc;
                if (chunk_full || image_done)
                begin
                    fill_next   = '0;
                    ack_next    = (ack_reg >= CH_Z) ? CH_A : ack_reg + 1'b1;
                    parity_next = par_flip;
                    led_next    = par_flip ? LED_LOADB : LED_LOADA;
                    res[1]      = mk_result(KIND_TX, ack_reg, '0,
                                            par_flip ? LED_LOADB : LED_LOADA, ST_RUN);
                    n           = CNT_W'(2);
                    if (image_done)
                    begin
                        phase_next = PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                if (byte_data == CH_C)
                begin
                    phase_next = PH_CRC;
                    fbi_next   = '0;
                    exp_next   = '0;
                end
                else
                begin
                    led_next   = LED_OFF;
                    res[0]     = mk_result(KIND_STATUS, 8'd0, '0, LED_OFF, ST_BAD_CMD);
                    n          = CNT_W'(1);
                    phase_next = PH_HALT;
                end
            end
            PH_CRC:
            begin
                exp_next = word_merged;
                if (fbi_reg != 2'd3)
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
                else
                begin
                    fbi_next   = '0;
                    res[0]     = mk_result(KIND_TX, ack_reg, '0, led_reg, ST_RUN);
                    res[1]     = mk_result(KIND_TX, calc[7:0], '0, led_reg, ST_RUN);
                    res[2]     = mk_result(KIND_TX, calc[15:8], '0, led_reg, ST_RUN);
                    res[3]     = mk_result(KIND_TX, calc[23:16], '0, led_reg, ST_RUN);
                    res[4]     = mk_result(KIND_TX, calc[31:24], '0, LED_OFF,
                                           (calc == word_merged) ? ST_OK : ST_CRC_BAD);
                    n          = CNT_W'(MAX_RES);
                    led_next   = LED_OFF;
                    phase_next = PH_HALT;
                end
            end
            default:
            begin
                // halted: bytes are dropped until reset
                n = '0;
            end
        endcase
    end

    // a byte with no results never waits on the output side
    assign proceed     = byte_valid && ((n == '0) || load_ok);
    assign byte_take   = proceed;
    assign bundle.load = proceed && (n != '0);
    assign bundle.cnt  = n;
    assign bundle.res  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            fbi_reg    <= '0;
            size_reg   <= '0;
            rcv_reg    <= '0;
            fill_reg   <= '0;
            parity_reg <= 1'b0;
            crc_reg    <= CRC_INIT;
            exp_reg    <= '0;
            ack_reg    <= CH_C;
            led_reg    <= LED_WAIT;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            if (max_image_bytes_we)
            begin
                limit_reg <= max_image_bytes;
            end
            if (proceed)
            begin
                phase_reg  <= phase_next;
                fbi_reg    <= fbi_next;
                size_reg   <= size_next;
                rcv_reg    <= rcv_next;
                fill_reg   <= fill_next;
                parity_reg <= parity_next;
                crc_reg    <= crc_next;
                exp_reg    <= exp_next;
                ack_reg    <= ack_next;
                led_reg    <= led_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/iur_out_seq.sv
// iur_out_seq: result register that shifts out a bundle of up to five results, one per cycle
// unless stalled; uses iur_pkg; loaded by iur_ctrl
`default_nettype none

module iur_out_seq
    import iur_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire bundle_t bundle,
    output logic         load_ok,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      head,
    output logic         head_last
);

    result_t [MAX_RES-1:0] res_reg;
    result_t [MAX_RES-1:0] res_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign load_ok   = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && take);
    assign head      = res_reg[0];
    assign head_last = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (bundle.load)
        begin
            res_next = bundle.res;
            cnt_next = bundle.cnt;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            res_next[MAX_RES-1] = '0;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RES))
        else $error("result count above bundle size");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |-> (cnt_reg == '0 || (cnt_reg == CNT_W'(1) && take)))
        else $error("bundle loaded over pending results");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |-> (bundle.cnt != '0 && bundle.cnt <= CNT_W'(MAX_RES)))
        else $error("empty or oversized bundle loaded");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        bundle.load |=> (out_valid && cnt_reg == $past(bundle.cnt)))
        else $error("loaded bundle not presented");
`endif

endmodule

`default_nettype wire
